// ===== rtl/core/dfr_pkg.sv =====
// Shared types, constants and helpers for the dielectric Fresnel/refraction pipeline.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package dfr_pkg;

  // Internal fixed point: unsigned Q.30 for cosines, eta and Schlick terms.
  localparam int          Q_BITS      = 30;
  localparam logic [30:0] Q_ONE       = 31'h4000_0000;
  localparam logic [15:0] SCALE_ONE   = 16'h8000;

  localparam int          ROOT_W      = 31;
  localparam int          RAD_W       = 61;
  localparam int          SQRT_STAGES = ROOT_W;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_INDEX_RATIO   = 3'd0;
  localparam logic [2:0] REG_INVERSE_INDEX = 3'd1;
  localparam logic [2:0] REG_BASE_REFL     = 3'd2;
  localparam logic [2:0] REG_ATTEN_RED     = 3'd3;
  localparam logic [2:0] REG_ATTEN_GREEN   = 3'd4;
  localparam logic [2:0] REG_ATTEN_BLUE    = 3'd5;

  typedef struct packed {
    logic [13:0]      index_ratio;
    logic [15:0]      inverse_index;
    logic [15:0]      base_refl;
    logic [2:0][15:0] log_atten;
  } cfg_t;

  // Per-item data that travels with the valid bit down the pipeline.
  typedef struct packed {
    logic [2:0][15:0] dir;
    logic [2:0][15:0] nrm;
    logic             ent;
    logic [31:0]      eta;
    logic [32:0]      ec;
    logic [2:0][15:0] mirror;
    logic             ok;
    logic [15:0]      sch;
  } carry_t;

  typedef struct packed {
    logic [2:0][15:0] mirror;
    logic [15:0]      reflect_scale;
    logic [2:0][15:0] refract;
    logic             refract_valid;
    logic [15:0]      transmit_scale;
    logic [2:0][15:0] atten;
  } result_t;

  function automatic logic [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      sat16 = 16'h7fff;
    end else if (x < -64'sd32768) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = x[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dfr_front.sv =====
// Front pipeline: dot product, cosine, mirror direction, Snell radicand and Schlick term.
// Eight register stages; uses dfr_pkg.
`default_nettype none
module dfr_front
  import dfr_pkg::*;
#(
  parameter int VEC_FRAC_BITS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire cfg_t             cfg,
  input  wire logic             in_v,
  input  wire logic [2:0][15:0] in_dir,
  input  wire logic [2:0][15:0] in_nrm,
  output logic                  out_v,
  output carry_t                out_c,
  output logic [RAD_W-1:0]      out_rad
);

  localparam int TWO_F = 2 * VEC_FRAC_BITS;
  localparam int SHR   = (TWO_F >= Q_BITS) ? TWO_F - Q_BITS : 0;
  localparam int SHL   = (TWO_F >= Q_BITS) ? 0 : Q_BITS - TWO_F;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (TWO_F - 1);

  // Stage 1: component products.
  logic                s1_v_r;
  logic [2:0][15:0]    s1_dir_r, s1_nrm_r;
  logic signed [31:0]  s1_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dir_r <= in_dir;
      s1_nrm_r <= in_nrm;
      for (int i = 0; i < 3; i++) s1_prod_r[i] <= $signed(in_dir[i]) * $signed(in_nrm[i]);
    end
  end

  // Stage 2: dot product, side of the surface, cosine and eta.
  logic signed [33:0] p_nxt;
  logic [33:0]        absp;
  logic [63:0]        cos64;
  logic [30:0]        cos_nxt;
  logic [31:0]        eta_nxt;
  carry_t             c2_nxt;

  always_comb begin
    p_nxt   = 34'(s1_prod_r[0]) + 34'(s1_prod_r[1]) + 34'(s1_prod_r[2]);
    absp    = p_nxt[33] ? 34'(-p_nxt) : p_nxt;
    cos64   = ({30'd0, absp} << SHL) >> SHR;
    cos_nxt = (cos64 > 64'(Q_ONE)) ? Q_ONE : cos64[30:0];
    eta_nxt = p_nxt[33] ? {1'b0, cfg.inverse_index, 15'd0} : {cfg.index_ratio, 18'd0};
    c2_nxt     = '0;
    c2_nxt.dir = s1_dir_r;
    c2_nxt.nrm = s1_nrm_r;
    c2_nxt.ent = p_nxt[33];
    c2_nxt.eta = eta_nxt;
  end

  logic               s2_v_r;
  carry_t             s2_c_r;
  logic signed [33:0] s2_p_r;
  logic [30:0]        s2_cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_c_r   <= c2_nxt;
      s2_p_r   <= p_nxt;
      s2_cos_r <= cos_nxt;
    end
  end

  // Stage 3: the wide products.
  logic signed [49:0] pn   [3];
  logic [61:0]        cc_full, xx_full;
  logic [63:0]        ee_full;
  logic [62:0]        ec_full;
  logic [30:0]        x_nxt;
  carry_t             c3_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) pn[i] = s2_p_r * $signed(s2_c_r.nrm[i]);
    cc_full   = s2_cos_r * s2_cos_r;
    ee_full   = s2_c_r.eta * s2_c_r.eta;
    ec_full   = s2_c_r.eta * s2_cos_r;
    x_nxt     = Q_ONE - s2_cos_r;
    xx_full   = x_nxt * x_nxt;
    c3_nxt    = s2_c_r;
    c3_nxt.ec = ec_full[62:30];
  end

  logic               s3_v_r;
  carry_t             s3_c_r;
  logic signed [50:0] s3_mm_r [3];
  logic [30:0]        s3_cc_r, s3_x_r, s3_x2_r;
  logic [33:0]        s3_ee_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_c_r  <= c3_nxt;
      for (int i = 0; i < 3; i++) s3_mm_r[i] <= {pn[i], 1'b0};
      s3_cc_r <= cc_full[60:30];
      s3_ee_r <= ee_full[63:30];
      s3_x_r  <= x_nxt;
      s3_x2_r <= xx_full[60:30];
    end
  end

  // Stage 4: mirror direction, sine squared, x cubed.
  logic signed [63:0] mq [3];
  logic [61:0]        x3_full;
  carry_t             c4_nxt;

  always_comb begin
    c4_nxt = s3_c_r;
    for (int i = 0; i < 3; i++) begin
      mq[i] = (64'(s3_mm_r[i]) + HALF) >>> TWO_F;
      c4_nxt.mirror[i] = sat16(64'($signed(s3_c_r.dir[i])) - mq[i]);
    end
    x3_full = s3_x2_r * s3_x_r;
  end

  logic        s4_v_r;
  carry_t      s4_c_r;
  logic [30:0] s4_sin2_r, s4_x_r, s4_x3_r;
  logic [33:0] s4_ee_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_c_r    <= c4_nxt;
      s4_sin2_r <= Q_ONE - s3_cc_r;
      s4_ee_r   <= s3_ee_r;
      s4_x_r    <= s3_x_r;
      s4_x3_r   <= x3_full[60:30];
    end
  end

  // Stage 5: eta squared times sine squared, x to the fourth.
  logic [64:0] e2_full;
  logic [61:0] x4_full;

  always_comb begin
    e2_full = s4_ee_r * s4_sin2_r;
    x4_full = s4_x3_r * s4_x_r;
  end

  logic        s5_v_r;
  carry_t      s5_c_r;
  logic [34:0] s5_e2s_r;
  logic [30:0] s5_x_r, s5_x4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_c_r   <= s4_c_r;
      s5_e2s_r <= e2_full[64:30];
      s5_x_r   <= s4_x_r;
      s5_x4_r  <= x4_full[60:30];
    end
  end

  // Stage 6: total internal reflection test and the square root radicand.
  logic             ok_nxt;
  logic [RAD_W-1:0] rad_nxt;
  logic [61:0]      x5_full;
  carry_t           c6_nxt;

  always_comb begin
    ok_nxt    = (s5_e2s_r <= 35'(Q_ONE));
    rad_nxt   = ok_nxt ? {Q_ONE - s5_e2s_r[30:0], 30'd0} : '0;
    x5_full   = s5_x4_r * s5_x_r;
    c6_nxt    = s5_c_r;
    c6_nxt.ok = ok_nxt;
  end

  logic             s6_v_r;
  carry_t           s6_c_r;
  logic [RAD_W-1:0] s6_rad_r;
  logic [30:0]      s6_x5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_c_r   <= c6_nxt;
      s6_rad_r <= rad_nxt;
      s6_x5_r  <= x5_full[60:30];
    end
  end

  // Stage 7: (1 - R0) times the fifth power.
  logic [15:0] r0;
  logic [30:0] r0q_nxt;
  logic [61:0] sp_full;

  always_comb begin
    r0      = (cfg.base_refl > SCALE_ONE) ? SCALE_ONE : cfg.base_refl;
    r0q_nxt = {r0, 15'd0};
    sp_full = (Q_ONE - r0q_nxt) * s6_x5_r;
  end

  logic             s7_v_r;
  carry_t           s7_c_r;
  logic [RAD_W-1:0] s7_rad_r;
  logic [30:0]      s7_r0q_r, s7_sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (en) s7_v_r <= s6_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_c_r   <= s6_c_r;
      s7_rad_r <= s6_rad_r;
      s7_r0q_r <= r0q_nxt;
      s7_sp_r  <= sp_full[60:30];
    end
  end

  // Stage 8: round the reflectance to Q1.15.
  logic [31:0] refl;
  logic [16:0] rnd;
  carry_t      c8_nxt;

  always_comb begin
    refl       = 32'(s7_r0q_r) + 32'(s7_sp_r);
    rnd        = 17'((refl + 32'h0000_4000) >> 15);
    c8_nxt     = s7_c_r;
    c8_nxt.sch = (rnd > 17'(SCALE_ONE)) ? SCALE_ONE : rnd[15:0];
  end

  logic             s8_v_r;
  carry_t           s8_c_r;
  logic [RAD_W-1:0] s8_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (en) s8_v_r <= s7_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_c_r   <= c8_nxt;
      s8_rad_r <= s7_rad_r;
    end
  end

  assign out_v   = s8_v_r;
  assign out_c   = s8_c_r;
  assign out_rad = s8_rad_r;

endmodule
`default_nettype wire

// ===== rtl/core/dfr_isqrt.sv =====
// Pipelined floor square root, one root bit per register stage.
// Carries the item's side data alongside; uses dfr_pkg.
`default_nettype none
module dfr_isqrt
  import dfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire carry_t           in_c,
  input  wire logic [RAD_W-1:0] in_rad,
  output logic                  out_v,
  output carry_t                out_c,
  output logic [ROOT_W-1:0]     out_root
);

  logic        v_r    [SQRT_STAGES];
  carry_t      c_r    [SQRT_STAGES];
  logic [61:0] rem_r  [SQRT_STAGES];
  logic [61:0] root_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STAGES - 1 - k));
    logic        sv;
    carry_t      sc;
    logic [61:0] srem, sroot, sum, rem_nxt, root_nxt;

    if (k == 0) begin : g_first
      assign sv    = in_v;
      assign sc    = in_c;
      assign srem  = 62'(in_rad);
      assign sroot = '0;
    end else begin : g_next
      assign sv    = v_r[k-1];
      assign sc    = c_r[k-1];
      assign srem  = rem_r[k-1];
      assign sroot = root_r[k-1];
    end

    always_comb begin
      sum = sroot + BIT;
      if (srem >= sum) begin
        rem_nxt  = srem - sum;
        root_nxt = (sroot >> 1) + BIT;
      end else begin
        rem_nxt  = srem;
        root_nxt = sroot >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= sv;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_r[k]    <= sc;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_v    = v_r[SQRT_STAGES-1];
  assign out_c    = c_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/dfr_back.sv =====
// Back pipeline: Snell refraction direction, scales and attenuation; last stage is the output register.
// Three register stages; uses dfr_pkg.
`default_nettype none
module dfr_back
  import dfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire cfg_t              cfg,
  input  wire logic              in_v,
  input  wire carry_t            in_c,
  input  wire logic [ROOT_W-1:0] in_root,
  output logic                   out_v,
  output result_t                out_res
);

  // Stage 1: g = eta*cos - sqrt(k).
  logic               b1_v_r;
  carry_t             b1_c_r;
  logic signed [34:0] b1_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else if (en) b1_v_r <= in_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b1_c_r <= in_c;
      b1_g_r <= $signed({2'b00, in_c.ec}) - $signed({4'd0, in_root});
    end
  end

  // Stage 2: eta*d and N*g per component; N flips the normal when leaving.
  logic signed [16:0] nn [3];
  logic signed [48:0] pe_nxt [3];
  logic signed [51:0] pg_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nn[i]     = b1_c_r.ent ? 17'($signed(b1_c_r.nrm[i])) : -17'($signed(b1_c_r.nrm[i]));
      pe_nxt[i] = $signed({1'b0, b1_c_r.eta}) * $signed(b1_c_r.dir[i]);
      pg_nxt[i] = nn[i] * b1_g_r;
    end
  end

  logic               b2_v_r;
  carry_t             b2_c_r;
  logic signed [48:0] b2_pe_r [3];
  logic signed [51:0] b2_pg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) b2_v_r <= 1'b0;
    else if (en) b2_v_r <= b1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2_c_r <= b1_c_r;
      for (int i = 0; i < 3; i++) begin
        b2_pe_r[i] <= pe_nxt[i];
        b2_pg_r[i] <= pg_nxt[i];
      end
    end
  end

  // Stage 3: round, saturate and assemble the result item.
  logic signed [63:0] s [3];
  result_t            res_nxt;

  always_comb begin
    res_nxt               = '0;
    res_nxt.mirror        = b2_c_r.mirror;
    res_nxt.refract_valid = b2_c_r.ok;
    res_nxt.reflect_scale = b2_c_r.ok ? b2_c_r.sch : SCALE_ONE;
    res_nxt.transmit_scale = SCALE_ONE - b2_c_r.sch;
    for (int i = 0; i < 3; i++) begin
      s[i] = (64'(b2_pe_r[i]) + 64'(b2_pg_r[i]) + (64'sd1 <<< (Q_BITS - 1))) >>> Q_BITS;
      res_nxt.refract[i] = b2_c_r.ok ? sat16(s[i]) : 16'd0;
      // A positive log extinction is held at zero; entering rays are not attenuated.
      res_nxt.atten[i]   = (b2_c_r.ent || !cfg.log_atten[i][15]) ? 16'd0 : cfg.log_atten[i];
    end
  end

  logic    b3_v_r;
  result_t b3_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b3_v_r <= 1'b0;
    else if (en) b3_v_r <= b2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) b3_res_r <= res_nxt;
  end

  assign out_v   = b3_v_r;
  assign out_res = b3_res_r;

endmodule
`default_nettype wire

// ===== rtl/core/dielectric_fresnel_refraction.sv =====
// Top level of the dielectric reflection/refraction/Fresnel pipeline: register file and stall.
// Instantiates dfr_front, dfr_isqrt and dfr_back; uses dfr_pkg.
//
//   channel | ports                        | handshake
//   --------+------------------------------+--------------------------------
//   input   | in_dir_*, in_normal_*        | in_valid / in_stall
//   output  | out_mirror_* ... out_atten_* | out_valid / out_stall
//   config  | psel penable pwrite paddr .. | APB, pready tied high
//
// One item enters per cycle while in_stall is low; each item passes through 8 front stages,
// 31 square root stages (one root bit each) and 3 back stages, the last being the output register.
// A stalled output freezes every stage at once, so in_stall follows out_valid and out_stall.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
`default_nettype none
module dielectric_fresnel_refraction
  import dfr_pkg::*;
#(
  parameter int VEC_FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_dir_x,
  input  wire logic [15:0] in_dir_y,
  input  wire logic [15:0] in_dir_z,
  input  wire logic [15:0] in_normal_x,
  input  wire logic [15:0] in_normal_y,
  input  wire logic [15:0] in_normal_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_mirror_x,
  output logic [15:0]      out_mirror_y,
  output logic [15:0]      out_mirror_z,
  output logic [15:0]      out_reflect_scale,
  output logic [15:0]      out_refract_x,
  output logic [15:0]      out_refract_y,
  output logic [15:0]      out_refract_z,
  output logic             out_refract_valid,
  output logic [15:0]      out_transmit_scale,
  output logic [15:0]      out_atten_red,
  output logic [15:0]      out_atten_green,
  output logic [15:0]      out_atten_blue,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_r;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_ratio   <= 14'd6144;
      cfg_r.inverse_index <= 16'd21845;
      cfg_r.base_refl     <= 16'd1311;
      cfg_r.log_atten     <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_INDEX_RATIO:   cfg_r.index_ratio   <= pwdata[13:0];
        REG_INVERSE_INDEX: cfg_r.inverse_index <= pwdata[15:0];
        REG_BASE_REFL:     cfg_r.base_refl     <= pwdata[15:0];
        REG_ATTEN_RED:     cfg_r.log_atten[0]  <= pwdata[15:0];
        REG_ATTEN_GREEN:   cfg_r.log_atten[1]  <= pwdata[15:0];
        REG_ATTEN_BLUE:    cfg_r.log_atten[2]  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_INDEX_RATIO:   prdata = 32'(cfg_r.index_ratio);
      REG_INVERSE_INDEX: prdata = 32'(cfg_r.inverse_index);
      REG_BASE_REFL:     prdata = 32'(cfg_r.base_refl);
      REG_ATTEN_RED:     prdata = 32'(cfg_r.log_atten[0]);
      REG_ATTEN_GREEN:   prdata = 32'(cfg_r.log_atten[1]);
      REG_ATTEN_BLUE:    prdata = 32'(cfg_r.log_atten[2]);
      default:           prdata = '0;
    endcase
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic             f_v, q_v;
  carry_t           f_c, q_c;
  logic [RAD_W-1:0] f_rad;
  logic [ROOT_W-1:0] q_root;
  result_t          res;

  dfr_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .in_v    (in_valid),
    .in_dir  ({in_dir_z, in_dir_y, in_dir_x}),
    .in_nrm  ({in_normal_z, in_normal_y, in_normal_x}),
    .out_v   (f_v),
    .out_c   (f_c),
    .out_rad (f_rad)
  );

  dfr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (f_v),
    .in_c     (f_c),
    .in_rad   (f_rad),
    .out_v    (q_v),
    .out_c    (q_c),
    .out_root (q_root)
  );

  dfr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .in_v    (q_v),
    .in_c    (q_c),
    .in_root (q_root),
    .out_v   (out_valid),
    .out_res (res)
  );

  assign out_mirror_x       = res.mirror[0];
  assign out_mirror_y       = res.mirror[1];
  assign out_mirror_z       = res.mirror[2];
  assign out_reflect_scale  = res.reflect_scale;
  assign out_refract_x      = res.refract[0];
  assign out_refract_y      = res.refract[1];
  assign out_refract_z      = res.refract[2];
  assign out_refract_valid  = res.refract_valid;
  assign out_transmit_scale = res.transmit_scale;
  assign out_atten_red      = res.atten[0];
  assign out_atten_green    = res.atten[1];
  assign out_atten_blue     = res.atten[2];

  // Total internal reflection gives a zero refraction vector and full reflectance.
  a_tir_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_refract_valid |->
      out_refract_x == 16'd0 && out_refract_y == 16'd0 && out_refract_z == 16'd0 &&
      out_reflect_scale == SCALE_ONE)
    else $error("refraction not cleared under total internal reflection");

  // With refraction present, the two scales split unity between them.
  a_scale_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refract_valid |->
      (17'(out_reflect_scale) + 17'(out_transmit_scale)) == 17'(SCALE_ONE))
    else $error("reflect and transmit scales do not sum to one");

  // Attenuation outputs never go positive.
  a_atten_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_atten_red[15] || out_atten_red == 16'd0) &&
                  (out_atten_green[15] || out_atten_green == 16'd0) &&
                  (out_atten_blue[15] || out_atten_blue == 16'd0))
    else $error("positive attenuation on output");

endmodule
`default_nettype wire
